[src/color_space_converter_top_macros.svh]
// Assertion macros for the color space converter.
// Used by color_space_converter_top; expects clk and rst_n in scope.
`ifndef COLOR_SPACE_CONVERTER_TOP_MACROS_SVH
`define COLOR_SPACE_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/csc_pkg.sv]
// Shared types and coefficients for the color space converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  typedef enum logic [0:0] {
    CFG_DIRECTION = 1'b0,
    CFG_STANDARD  = 1'b1
  } cfg_reg_t;

  typedef logic signed [8:0] coef_t;

  // YUV to RGB
  localparam coef_t Y_OFFSET   = 9'sd16;
  localparam coef_t C_OFFSET   = 9'sd128;
  localparam coef_t Y_GAIN     = 9'sd149;
  localparam coef_t K601_R     = 9'sd102;
  localparam coef_t K601_B     = 9'sd129;
  localparam coef_t K601_GU    = 9'sd50;
  localparam coef_t K601_GV    = 9'sd104;
  localparam coef_t K709_R     = 9'sd115;
  localparam coef_t K709_B     = 9'sd135;
  localparam coef_t K709_GU    = 9'sd27;
  localparam coef_t K709_GV    = 9'sd68;

  // RGB to YUV
  localparam coef_t W601_R     = 9'sd77;
  localparam coef_t W601_G     = 9'sd150;
  localparam coef_t W601_B     = 9'sd29;
  localparam coef_t W709_R     = 9'sd54;
  localparam coef_t W709_G     = 9'sd184;
  localparam coef_t W709_B     = 9'sd18;
  localparam coef_t S601_U     = 9'sd127;
  localparam coef_t S601_V     = 9'sd160;
  localparam coef_t S709_U     = 9'sd121;
  localparam coef_t S709_V     = 9'sd143;
  localparam coef_t LUMA_SCALE = 9'sd110;

endpackage

`default_nettype wire

[src/color_space_converter_top.sv]
// Color space converter top level: YUV <-> RGB, BT.601 / BT.709, 4-stage pipeline.
// Depends on csc_pkg and color_space_converter_top_macros.svh.
//
//   channel  ports                                  handshake
//   input    in_c0 in_c1 in_c2                      start & !busy
//   result   out_c0 out_c1 out_c2                   out_valid, one-cycle strobe
//   config   cfg_index cfg_data                     cfg_valid & cfg_ready
//
// One pixel per clock; busy never rises. Each pixel passes through the input
// register, product stage, shift/sum stage and clamp/scale stage.
// Direction and standard are sampled with each pixel and travel down the pipe.
// rst_n is synchronous and clears the valid bits and the config registers.
// The receiver cannot stall, so the pipe never holds.
`timescale 1ns / 1ps
`default_nettype none
`include "color_space_converter_top_macros.svh"

module color_space_converter_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [7:0]        in_c0,
  input  wire logic [7:0]        in_c1,
  input  wire logic [7:0]        in_c2,
  output logic                   out_valid,
  output logic [7:0]             out_c0,
  output logic [7:0]             out_c1,
  output logic [7:0]             out_c2,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire csc_pkg::cfg_reg_t cfg_index,
  input  wire logic [7:0]        cfg_data
);
  import csc_pkg::*;

  function automatic logic [7:0] clamp255(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 11'sd0) res = 8'd0;
    else if (x > 11'sd255) res = 8'd255;
    else res = x[7:0];
    return res;
  endfunction

  logic dir_r, std_r;
  logic v1_r, v2_r, v3_r, v4_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  wire accept = start & ~busy;

  // ---------------- config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      std_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIRECTION: dir_r <= cfg_data[0];
        CFG_STANDARD:  std_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // ---------------- stage 1: input register
  logic [7:0] a1_r, b1_r, c1_r;
  logic       dir1_r, std1_r;

  always_ff @(posedge clk) begin
    a1_r   <= in_c0;
    b1_r   <= in_c1;
    c1_r   <= in_c2;
    dir1_r <= dir_r;
    std1_r <= std_r;
  end

  // ---------------- stage 2: products
  logic signed [8:0]  a1s, b1s, c1s, tu, tv;
  logic signed [9:0]  yoff;
  coef_t              kr, kb, gu, gv, wr, wg, wb;
  logic signed [17:0] py_nxt, ls_nxt;
  logic signed [15:0] pr_nxt, pb_nxt, pg_nxt;

  always_comb begin
    a1s  = $signed({1'b0, a1_r});
    b1s  = $signed({1'b0, b1_r});
    c1s  = $signed({1'b0, c1_r});
    yoff = 10'(a1s) - 10'(Y_OFFSET);
    tu   = b1s - C_OFFSET;
    tv   = c1s - C_OFFSET;
    kr   = std1_r ? K709_R  : K601_R;
    kb   = std1_r ? K709_B  : K601_B;
    gu   = std1_r ? K709_GU : K601_GU;
    gv   = std1_r ? K709_GV : K601_GV;
    wr   = std1_r ? W709_R  : W601_R;
    wg   = std1_r ? W709_G  : W601_G;
    wb   = std1_r ? W709_B  : W601_B;
    py_nxt = 18'(yoff) * 18'(Y_GAIN);
    pr_nxt = 16'(tv) * 16'(kr);
    pb_nxt = 16'(tu) * 16'(kb);
    pg_nxt = 16'(tu) * 16'(gu) + 16'(tv) * 16'(gv);
    ls_nxt = 18'(a1s) * 18'(wr) + 18'(b1s) * 18'(wg) + 18'(c1s) * 18'(wb);
  end

  logic signed [17:0] py2_r, ls2_r;
  logic signed [15:0] pr2_r, pb2_r, pg2_r;
  logic [7:0]         a2_r, c2_r;
  logic               dir2_r, std2_r;

  always_ff @(posedge clk) begin
    py2_r  <= py_nxt;
    pr2_r  <= pr_nxt;
    pb2_r  <= pb_nxt;
    pg2_r  <= pg_nxt;
    ls2_r  <= ls_nxt;
    a2_r   <= a1_r;
    c2_r   <= c1_r;
    dir2_r <= dir1_r;
    std2_r <= std1_r;
  end

  // ---------------- stage 3: floor shifts and sums
  logic signed [10:0] ty, tr, tb, tg;
  logic signed [10:0] sr_nxt, sg_nxt, sb_nxt;
  logic [8:0]         lum_nxt;
  logic signed [9:0]  du_nxt, dv_nxt;

  always_comb begin
    ty      = 11'(py2_r >>> 7);
    tr      = 11'(pr2_r >>> 6);
    tb      = 11'(pb2_r >>> 6);
    tg      = 11'(pg2_r >>> 7);
    sr_nxt  = ty + tr;
    sg_nxt  = ty - tg;
    sb_nxt  = ty + tb;
    lum_nxt = ls2_r[16:8];
    du_nxt  = $signed({2'b00, c2_r}) - $signed({1'b0, lum_nxt});
    dv_nxt  = $signed({2'b00, a2_r}) - $signed({1'b0, lum_nxt});
  end

  logic signed [10:0] sr3_r, sg3_r, sb3_r;
  logic [8:0]         lum3_r;
  logic signed [9:0]  du3_r, dv3_r;
  logic               dir3_r, std3_r;

  always_ff @(posedge clk) begin
    sr3_r  <= sr_nxt;
    sg3_r  <= sg_nxt;
    sb3_r  <= sb_nxt;
    lum3_r <= lum_nxt;
    du3_r  <= du_nxt;
    dv3_r  <= dv_nxt;
    dir3_r <= dir2_r;
    std3_r <= std2_r;
  end

  // ---------------- stage 4: clamp (YUV->RGB) or scale and offset (RGB->YUV)
  coef_t              su, sv;
  logic signed [17:0] py4, pu4, pv4;
  logic [7:0]         o0_nxt, o1_nxt, o2_nxt;

  always_comb begin
    su  = std3_r ? S709_U : S601_U;
    sv  = std3_r ? S709_V : S601_V;
    py4 = 18'($signed({1'b0, lum3_r})) * 18'(LUMA_SCALE);
    pu4 = 18'(du3_r) * 18'(su);
    pv4 = 18'(dv3_r) * 18'(sv);
    if (dir3_r) begin
      // results wrap to 8 bits, no clamp on this path
      o0_nxt = 8'((py4 >>> 7) + 18'(Y_OFFSET));
      o1_nxt = 8'((pu4 >>> 8) + 18'(C_OFFSET));
      o2_nxt = 8'((pv4 >>> 8) + 18'(C_OFFSET));
    end else begin
      o0_nxt = clamp255(sr3_r);
      o1_nxt = clamp255(sg3_r);
      o2_nxt = clamp255(sb3_r);
    end
  end

  logic [7:0] o0_r, o1_r, o2_r;

  always_ff @(posedge clk) begin
    o0_r <= o0_nxt;
    o1_r <= o1_nxt;
    o2_r <= o2_nxt;
  end

  assign out_valid = v4_r;
  assign out_c0    = o0_r;
  assign out_c1    = o1_r;
  assign out_c2    = o2_r;

  // ---------------- assertions
  `CSC_ASSERT_NEXT(a_latency, accept, ##3 out_valid, "accepted pixel did not emerge after four cycles")
  `CSC_ASSERT_NOW(a_no_spurious, out_valid, $past(accept, 4), "result strobe without a matching transaction")
  `CSC_ASSERT_NEXT(a_cfg_dir, cfg_valid && cfg_ready && cfg_index == CFG_DIRECTION, dir_r == $past(cfg_data[0]), "direction write not taken")

endmodule

`default_nettype wire
